### sv/bam_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bam_pkg
// Shared types and constants for the block-average ASCII mapper.
// ============================================================================
package bam_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 4'd3;
    localparam int CFG_DATA_W = 13;

    // Register widths and reset values
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;
    localparam int CELL_BITS  = 5;
    localparam logic [IMG_W_BITS-1:0] IMG_W_RESET  = 11'd1024;
    localparam logic [IMG_H_BITS-1:0] IMG_H_RESET  = 13'd768;
    localparam logic [CELL_BITS-1:0]  CELL_W_RESET = 5'd3;
    localparam logic [CELL_BITS-1:0]  CELL_H_RESET = 5'd6;

    // Frame height limit and row counter width
    localparam int MAX_HEIGHT = 4096;
    localparam int Y_W        = 12;

    // Field widths
    localparam int PIXEL_W = 8;
    localparam int CHAR_W  = 7;

    // Level mapping constants
    localparam logic [7:0]        FULL_SCALE   = 8'd255;
    localparam logic [6:0]        TOP_LEVEL    = 7'd69;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;
    localparam int RAMP_LEN = 70;

    // Brightness ramp, darkest first
    localparam logic [CHAR_W-1:0] RAMP [RAMP_LEN] = '{
        7'd32,  7'd46,  7'd39,  7'd96,  7'd94,  7'd34,  7'd44,  7'd58,  7'd59,
        7'd73,  7'd108, 7'd33,  7'd105, 7'd62,  7'd60,  7'd126, 7'd43,  7'd95,
        7'd45,  7'd63,  7'd93,  7'd91,  7'd125, 7'd123,
        7'd49,  7'd41,  7'd40,  7'd124, 7'd92,  7'd47,  7'd116, 7'd102, 7'd106,
        7'd114, 7'd120, 7'd110, 7'd117, 7'd118, 7'd99,
        7'd122, 7'd88,  7'd89,  7'd85,  7'd74,  7'd67,  7'd76,  7'd81,  7'd48,
        7'd79,  7'd90,  7'd109, 7'd119, 7'd113, 7'd112,
        7'd100, 7'd98,  7'd107, 7'd104, 7'd97,  7'd111, 7'd42,  7'd35,  7'd77,
        7'd87,  7'd38,  7'd56,  7'd37,  7'd66,  7'd64,
        7'd36
    };

    // Flags carried with each cell job from front to back
    typedef struct packed {
        logic has_nl;   // row ends here: newline follows the character
        logic eof;      // that newline closes the frame
    } job_flags_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADJ,
        BK_DIV,
        BK_CHAR,
        BK_NL
    } back_state_t;

endpackage

### sv/block_average_ascii_mapper_top.sv
`timescale 1ns / 1ps
// ============================================================================
// block_average_ascii_mapper_top
// Grey raster to ASCII art: block averages mapped onto a 70-level ramp.
//
//   channel   direction  handshake               word
//   pixel     in         pixel_valid/pixel_stall pixel[7:0]
//   out       out        out_valid/out_stall     char_code[6:0], end_of_frame
//   cfg       in         cfg_valid/cfg_ready     cfg_index[3:0], cfg_data[12:0]
//
// Pixels are taken one per cycle while the four-entry job queue has room.
// Each finished cell of a band's last row passes the back-end divider
// (load, multiply, adjust, 7 quotient steps, emit), and a row's newline
// takes its own state; that divider sets the sustained rate on those rows.
// Reset clears control state only; the line store needs no clearing pass.
// Output stall holds the output word and, once the queue fills, stalls pixels.
// ============================================================================
module block_average_ascii_mapper_top import bam_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_CELL_SIDE = 16,
    parameter int PIXEL_BITS    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel channel
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIXEL_W-1:0]    pixel,
    // character channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAR_W-1:0]     char_code,
    output logic                  end_of_frame,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W   = PIXEL_BITS + $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE);
    localparam int CNT_W   = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_W     = $bits(job_flags_t) + SUM_W + CNT_W;

    logic [IMG_W_BITS-1:0] image_width_reg;
    logic [IMG_H_BITS-1:0] image_height_reg;
    logic [CELL_BITS-1:0]  cell_width_reg;
    logic [CELL_BITS-1:0]  cell_height_reg;
    logic                  cfg_write;
    logic                  restart;

    logic             f_push;
    job_flags_t       f_flags;
    logic [SUM_W-1:0] f_total;
    logic [CNT_W-1:0] f_count;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [Q_W-1:0]   q_data;
    job_flags_t       q_flags;
    logic [SUM_W-1:0] q_total;
    logic [CNT_W-1:0] q_count;

    // Configuration registers; any known register write restarts the frame
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && (cfg_index == CFG_IMAGE_WIDTH ||
                                     cfg_index == CFG_IMAGE_HEIGHT ||
                                     cfg_index == CFG_CELL_WIDTH ||
                                     cfg_index == CFG_CELL_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_RESET;
            image_height_reg <= IMG_H_RESET;
            cell_width_reg   <= CELL_W_RESET;
            cell_height_reg  <= CELL_H_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_BITS-1:0];
                CFG_CELL_WIDTH:   cell_width_reg   <= cfg_data[CELL_BITS-1:0];
                CFG_CELL_HEIGHT:  cell_height_reg  <= cfg_data[CELL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Front: intake and cell accumulation
    bam_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_CELL_SIDE (MAX_CELL_SIDE),
        .PIXEL_BITS    (PIXEL_BITS),
        .SUM_W         (SUM_W),
        .CNT_W         (CNT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .cell_width   (cell_width_reg),
        .cell_height  (cell_height_reg),
        .restart      (restart),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .job_push     (f_push),
        .job_full     (q_full),
        .job_flags    (f_flags),
        .job_total    (f_total),
        .job_count    (f_count)
    );

    // Job queue between front and back
    bam_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_flags, f_total, f_count}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    assign {q_flags, q_total, q_count} = q_data;

    // Back: level division and character output
    bam_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (q_empty),
        .job_pop      (q_pop),
        .job_flags    (q_flags),
        .job_total    (q_total),
        .job_count    (q_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_code    (char_code),
        .end_of_frame (end_of_frame)
    );

endmodule

### sv/bam_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// bam_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/bam_front.sv
`timescale 1ns / 1ps
// ============================================================================
// bam_front
// Pixel intake: raster position tracking, per-cell row sums, band line
// store, and issue of finished cells to the job queue.
// ============================================================================
module bam_front import bam_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_CELL_SIDE = 16,
    parameter int PIXEL_BITS    = 8,
    parameter int SUM_W         = 16,
    parameter int CNT_W         = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration, raw register values
    input  logic [IMG_W_BITS-1:0] image_width,
    input  logic [IMG_H_BITS-1:0] image_height,
    input  logic [CELL_BITS-1:0]  cell_width,
    input  logic [CELL_BITS-1:0]  cell_height,
    input  logic                  restart,
    // pixel channel
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIXEL_W-1:0]    pixel,
    // job queue push side
    output logic                  job_push,
    input  logic                  job_full,
    output job_flags_t            job_flags,
    output logic [SUM_W-1:0]      job_total,
    output logic [CNT_W-1:0]      job_count
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_CELL_SIDE);
    localparam int RUN_W = PIXEL_BITS + CW;
    localparam logic [PIXEL_W-1:0] PIX_MASK =
        (PIXEL_BITS >= PIXEL_W) ? '1 : PIXEL_W'((1 << PIXEL_BITS) - 1);

    // Scan state
    logic [XW-1:0]    x_pos_reg, x_pos_next;
    logic [Y_W-1:0]   y_pos_reg, y_pos_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [CW-1:0]    row_reg, row_next;
    logic [XW-1:0]    ci_reg, ci_next;
    logic [RUN_W-1:0] run_sum_reg, run_sum_next;

    // Second stage: one pixel waiting for its line store read
    logic             sb_valid_reg;
    logic             sb_cell_end_reg;
    logic             sb_band_end_reg;
    logic             sb_row_end_reg;
    logic             sb_frame_end_reg;
    logic             sb_use_store_reg;
    logic             sb_byp_reg;
    logic [RUN_W-1:0] sb_row_sum_reg;
    logic [CNT_W-1:0] sb_count_reg;
    logic [XW-1:0]    sb_ci_reg;
    logic [SUM_W-1:0] byp_data_reg;

    // Effective (clamped) sizes, minus one
    logic [XW-1:0]  w_m1;
    logic [Y_W-1:0] h_m1;
    logic [CW-1:0]  cw_m1;
    logic [CW-1:0]  ch_m1;

    logic             accept;
    logic             row_end, cell_end, frame_end, band_end;
    logic [RUN_W-1:0] sum_row;
    logic [CW:0]      col_p1, row_p1;
    logic [2*CW+1:0]  cnt_full;

    logic             rd_en;
    logic [SUM_W-1:0] rd_data;
    logic [SUM_W-1:0] store_val;
    logic [SUM_W-1:0] total;
    logic             sb_push;
    logic             sb_fire;
    logic             wr_en;

    // Clamp configured sizes into their legal ranges
    always_comb
    begin
        if (image_width == '0)
            w_m1 = '0;
        else if (32'(image_width) > MAX_WIDTH)
            w_m1 = XW'(MAX_WIDTH - 1);
        else
            w_m1 = XW'(image_width - 11'd1);

        if (image_height == '0)
            h_m1 = '0;
        else if (32'(image_height) > MAX_HEIGHT)
            h_m1 = Y_W'(MAX_HEIGHT - 1);
        else
            h_m1 = Y_W'(image_height - 13'd1);

        if (cell_width == '0)
            cw_m1 = '0;
        else if (32'(cell_width) > MAX_CELL_SIDE)
            cw_m1 = CW'(MAX_CELL_SIDE - 1);
        else
            cw_m1 = CW'(cell_width - 5'd1);

        if (cell_height == '0)
            ch_m1 = '0;
        else if (32'(cell_height) > MAX_CELL_SIDE)
            ch_m1 = CW'(MAX_CELL_SIDE - 1);
        else
            ch_m1 = CW'(cell_height - 5'd1);
    end

    // Position decode for the pixel at the port
    assign row_end   = x_pos_reg >= w_m1;
    assign cell_end  = row_end || (col_reg >= cw_m1);
    assign frame_end = y_pos_reg >= h_m1;
    assign band_end  = frame_end || (row_reg >= ch_m1);
    assign accept    = pixel_valid && !pixel_stall;
    assign sum_row   = run_sum_reg + RUN_W'(pixel & PIX_MASK);
    assign col_p1    = {1'b0, col_reg} + (CW+1)'(1);
    assign row_p1    = {1'b0, row_reg} + (CW+1)'(1);
    assign cnt_full  = (2*CW+2)'(col_p1) * (2*CW+2)'(row_p1);

    // Scan counters
    always_comb
    begin
        x_pos_next   = x_pos_reg;
        y_pos_next   = y_pos_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        ci_next      = ci_reg;
        run_sum_next = run_sum_reg;
        if (restart)
        begin
            x_pos_next   = '0;
            y_pos_next   = '0;
            col_next     = '0;
            row_next     = '0;
            ci_next      = '0;
            run_sum_next = '0;
        end
        else if (accept)
        begin
            run_sum_next = cell_end ? '0 : sum_row;
            if (row_end)
            begin
                row_next   = band_end ? '0 : row_reg + CW'(1);
                y_pos_next = frame_end ? '0 : y_pos_reg + Y_W'(1);
                x_pos_next = '0;
                col_next   = '0;
                ci_next    = '0;
            end
            else
            begin
                x_pos_next = x_pos_reg + XW'(1);
                if (cell_end)
                begin
                    col_next = '0;
                    ci_next  = ci_reg + XW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg   <= '0;
            y_pos_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            ci_reg      <= '0;
            run_sum_reg <= '0;
        end
        else
        begin
            x_pos_reg   <= x_pos_next;
            y_pos_reg   <= y_pos_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            ci_reg      <= ci_next;
            run_sum_reg <= run_sum_next;
        end
    end

    // Line store: partial cell sums of the band so far
    assign rd_en = accept && cell_end && (row_reg != '0);

    bam_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (sb_ci_reg),
        .wr_data (total),
        .rd_en   (rd_en),
        .rd_addr (ci_reg),
        .rd_data (rd_data)
    );

    // Second stage: finish the cell total, then store it or hand it on
    assign store_val   = sb_byp_reg ? byp_data_reg : rd_data;
    assign total       = SUM_W'(sb_row_sum_reg) + (sb_use_store_reg ? store_val : '0);
    assign sb_push     = sb_cell_end_reg && sb_band_end_reg;
    assign sb_fire     = sb_valid_reg && (!sb_push || !job_full);
    assign pixel_stall = sb_valid_reg && !sb_fire;
    assign wr_en       = sb_fire && sb_cell_end_reg && !sb_band_end_reg;

    assign job_push         = sb_fire && sb_push;
    assign job_flags.has_nl = sb_row_end_reg;
    assign job_flags.eof    = sb_row_end_reg && sb_frame_end_reg;
    assign job_total        = total;
    assign job_count        = sb_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            sb_valid_reg <= 1'b1;
        end
        else if (sb_fire)
        begin
            sb_valid_reg <= 1'b0;
        end
    end

    // Stage payload; a write to the entry being read this cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sb_cell_end_reg  <= cell_end;
            sb_band_end_reg  <= band_end;
            sb_row_end_reg   <= row_end;
            sb_frame_end_reg <= frame_end;
            sb_use_store_reg <= row_reg != '0;
            sb_row_sum_reg   <= sum_row;
            sb_count_reg     <= CNT_W'(cnt_full);
            sb_ci_reg        <= ci_reg;
            sb_byp_reg       <= rd_en && wr_en && (sb_ci_reg == ci_reg);
            byp_data_reg     <= total;
        end
    end

endmodule

### sv/bam_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// bam_queue
// Small register FIFO carrying cell jobs from the front to the back.
// ============================================================================
module bam_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full     = count_reg == (AW+1)'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/bam_back.sv
`timescale 1ns / 1ps
// ============================================================================
// bam_back
// Character generation: exact ceiling of sum*69/(count*255) by a
// shift-subtract divider, ramp lookup, newline insertion, output register.
// ============================================================================
module bam_back import bam_pkg::*; #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    // job queue pop side
    input  logic              job_empty,
    output logic              job_pop,
    input  job_flags_t        job_flags,
    input  logic [SUM_W-1:0]  job_total,
    input  logic [CNT_W-1:0]  job_count,
    // character channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] char_code,
    output logic              end_of_frame
);

    localparam int CMP_W = ((SUM_W > CNT_W + 8) ? SUM_W : CNT_W + 8) + 8;
    localparam logic [2:0] LAST_STEP = 3'd6;

    back_state_t state_reg, state_next;

    job_flags_t        flags_reg;
    logic [SUM_W-1:0]  total_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CMP_W-1:0]  num_reg;
    logic [CMP_W-1:0]  den_reg;
    logic [6:0]        q_reg;
    logic [2:0]        step_reg;
    logic              sat_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_code_reg;
    logic              eof_reg;

    logic              slot_free;
    logic              out_load;
    logic [CHAR_W-1:0] out_code;
    logic              out_eof;
    logic [CMP_W-1:0]  adj_sum;
    logic [CMP_W-1:0]  den_shift;
    logic [6:0]        level;

    assign slot_free = !out_valid_reg || !out_stall;
    assign adj_sum   = num_reg + den_reg - CMP_W'(1);
    assign den_shift = den_reg << step_reg;
    assign level     = (sat_reg || (q_reg > TOP_LEVEL)) ? TOP_LEVEL : q_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!job_empty) state_next = BK_MUL;
            BK_MUL:  state_next = BK_ADJ;
            BK_ADJ:  state_next = BK_DIV;
            BK_DIV:  if (step_reg == '0) state_next = BK_CHAR;
            BK_CHAR:
            begin
                if (slot_free)
                    state_next = flags_reg.has_nl ? BK_NL : BK_IDLE;
            end
            BK_NL:   if (slot_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        job_pop  = 1'b0;
        out_load = 1'b0;
        out_code = NEWLINE_CODE;
        out_eof  = 1'b0;
        unique case (state_reg)
            BK_IDLE: job_pop = !job_empty;
            BK_MUL, BK_ADJ, BK_DIV: ;
            BK_CHAR:
            begin
                out_load = slot_free;
                out_code = RAMP[level];
            end
            BK_NL:
            begin
                out_load = slot_free;
                out_eof  = flags_reg.eof;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Divider datapath: numerator sum*69 + den - 1, restoring over 7 bits
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            flags_reg <= job_flags;
            total_reg <= job_total;
            cnt_reg   <= job_count;
        end
        if (state_reg == BK_MUL)
        begin
            num_reg <= CMP_W'(total_reg) * CMP_W'(TOP_LEVEL);
            den_reg <= CMP_W'(cnt_reg) * CMP_W'(FULL_SCALE);
        end
        if (state_reg == BK_ADJ)
        begin
            num_reg  <= adj_sum;
            sat_reg  <= adj_sum >= (den_reg << 7);
            q_reg    <= '0;
            step_reg <= LAST_STEP;
        end
        if (state_reg == BK_DIV)
        begin
            if (num_reg >= den_shift)
            begin
                num_reg          <= num_reg - den_shift;
                q_reg[step_reg]  <= 1'b1;
            end
            step_reg <= step_reg - 3'd1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            char_code_reg <= out_code;
            eof_reg       <= out_eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign char_code    = char_code_reg;
    assign end_of_frame = eof_reg;

endmodule

### sv/bam_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// bam_checker
// Port-level checks for the ASCII mapper, bound onto the top level.
// ============================================================================
module bam_checker import bam_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              pixel_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CHAR_W-1:0] char_code,
    input logic              end_of_frame
);

    logic out_accept;
    logic prev_nl_reg;

    assign out_accept = out_valid && !out_stall;

    // Remember whether the last accepted word was a newline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_nl_reg <= 1'b0;
        else if (out_accept)
            prev_nl_reg <= char_code == NEWLINE_CODE;
    end

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(end_of_frame))
        else $error("output word changed while stalled");

    // Reset leaves no output pending and no pixel stall
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !pixel_stall)
        else $error("activity right after reset");

    // Frame end is flagged only on a newline
    a_eof_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> char_code == NEWLINE_CODE)
        else $error("end_of_frame on a character word");

    // Every text row holds at least one character
    a_no_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && char_code == NEWLINE_CODE |-> !prev_nl_reg)
        else $error("two newlines in a row");

endmodule

bind block_average_ascii_mapper_top bam_checker u_bam_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .end_of_frame (end_of_frame)
);
